// ===== src/verlet_point_wall_pushback_unit_macros.svh =====
// assertion macros for the verlet point wall push-back unit
`ifndef VERLET_POINT_WALL_PUSHBACK_UNIT_MACROS_SVH
`define VERLET_POINT_WALL_PUSHBACK_UNIT_MACROS_SVH
// assert a property on the rising clock, disabled in reset
`define VPW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assert a property on the rising clock, also in reset
`define VPW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/vpw_pkg.sv =====
// package for the verlet point wall push-back unit
`timescale 1ns / 1ps
package vpw_pkg;
  localparam int MaxWalls        = 8;
  localparam int MaxBackoffSteps = 1024;
  localparam int WallIdxW        = $clog2(MaxWalls);
  localparam int WallCntW        = 4;
  localparam int StepCntW        = $clog2(MaxBackoffSteps) + 1;
  localparam int WallRamW        = 32 + 32 + 31 + 31;

  localparam logic [1:0] CfgAccelX    = 2'd0;
  localparam logic [1:0] CfgAccelY    = 2'd1;
  localparam logic [1:0] CfgWallCount = 2'd2;

  localparam logic CmdPoint = 1'b0;
  localparam logic CmdWall  = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_SQRT  = 10'b0000000010,
    ST_DIVX  = 10'b0000000100,
    ST_DIVY  = 10'b0000001000,
    ST_RD    = 10'b0000010000,
    ST_TEST  = 10'b0000100000,
    ST_PUSH  = 10'b0001000000,
    ST_OUT   = 10'b0010000000,
    ST_WAIT  = 10'b0100000000,
    ST_SQ    = 10'b1000000000
  } state_t;

  // saturate a 34-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh07FFFFFFF;
    lo = -34'sh080000000;
    if (v > hi) sat32 = 32'sh7FFFFFFF;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage

// ===== src/vpw_if.sv =====
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface vpw_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] prev_x;
  logic [31:0] prev_y;
  logic        hooked;
  logic [2:0]  wall_index;
  logic [31:0] wall_left;
  logic [31:0] wall_top;
  logic [30:0] wall_width;
  logic [30:0] wall_height;
  modport source (output valid, cmd, pos_x, pos_y, prev_x, prev_y, hooked, wall_index,
                  wall_left, wall_top, wall_width, wall_height, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, prev_x, prev_y, hooked, wall_index,
                wall_left, wall_top, wall_width, wall_height, output ready);
endinterface

interface vpw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_x;
  logic [31:0] new_y;
  logic [31:0] new_prev_x;
  logic [31:0] new_prev_y;
  logic        pushed_back;
  logic        stuck;
  modport source (output valid, new_x, new_y, new_prev_x, new_prev_y, pushed_back, stuck,
                  input ready);
  modport sink (input valid, new_x, new_y, new_prev_x, new_prev_y, pushed_back, stuck,
                output ready);
endinterface

interface vpw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/vpw_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module vpw_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/verlet_point_wall_pushback_unit.sv =====
// top level: verlet step of one point with wall push-back
// flow: one point in flight; input ready again in the cycle after the result beat;
//   a wall beat is written into the ram when it is accepted; the square root and the
//   two divides (x and y step) set the rate
// reset: synchronous active-low rst_n clears state and config registers, wall ram undefined
`timescale 1ns / 1ps
`include "verlet_point_wall_pushback_unit_macros.svh"
module verlet_point_wall_pushback_unit
  import vpw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  vpw_in_if.sink    in_ch,
  vpw_out_if.source out_ch,
  vpw_cfg_if.sink   cfg_ch
);
  state_t state_r, state_nxt;

  logic signed [31:0] accel_x_r, accel_y_r;
  logic [WallCntW-1:0] wall_count_r;

  logic signed [31:0] px_r, py_r, x_r, y_r, vx_r, vy_r, sx_r, sy_r;
  logic hooked_r, pushed_r, stuck_r;
  logic [63:0] rem_r;   // divide partial remainder
  logic [63:0] root_r;
  logic [63:0] sq_r;
  logic [5:0]  iter_r;
  logic [31:0] mag_r;
  logic [47:0] dnum_r;  // shifted dividend
  logic [47:0] quo_r;
  logic [35:0] dden_r;
  logic [WallIdxW:0] wall_r;
  logic [StepCntW-1:0] steps_r;
  logic [WallCntW-1:0] nwalls;

  logic ram_we;
  logic [WallIdxW-1:0] ram_raddr;
  logic [WallRamW-1:0] ram_wdata, ram_rdata;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign nwalls = (wall_count_r > WallCntW'(MaxWalls)) ? WallCntW'(MaxWalls) : wall_count_r;

  assign ram_we    = in_ch.valid && in_ch.ready && (in_ch.cmd == CmdWall)
                     && ({1'b0, in_ch.wall_index} < 4'(MaxWalls));
  assign ram_wdata = {in_ch.wall_left, in_ch.wall_top, in_ch.wall_width, in_ch.wall_height};
  assign ram_raddr = wall_r[WallIdxW-1:0];

  vpw_ram #(.Width(WallRamW), .Depth(MaxWalls)) u_wall_ram (
    .clk(clk), .we(ram_we), .waddr(in_ch.wall_index[WallIdxW-1:0]), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_x_r <= '0; accel_y_r <= '0; wall_count_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CfgAccelX:    accel_x_r <= cfg_ch.data;
        CfgAccelY:    accel_y_r <= cfg_ch.data;
        CfgWallCount: wall_count_r <= cfg_ch.data[WallCntW-1:0];
        default: ;
      endcase
    end
  end

  // velocity and advanced position for an accepted point
  logic signed [31:0] vx_in, vy_in, nx_in, ny_in;
  always_comb begin
    vx_in = sat32(34'(signed'(in_ch.pos_x)) - 34'(signed'(in_ch.prev_x)) + 34'(accel_x_r));
    vy_in = sat32(34'(signed'(in_ch.pos_y)) - 34'(signed'(in_ch.prev_y)) + 34'(accel_y_r));
    nx_in = sat32(34'(signed'(in_ch.pos_x)) + 34'(vx_in));
    ny_in = sat32(34'(signed'(in_ch.pos_y)) + 34'(vy_in));
  end

  // velocity magnitudes and their squares
  logic [31:0] ax_v, ay_v;
  logic [63:0] sqx_v, sqy_v;
  always_comb begin
    ax_v  = vx_r[31] ? 32'(-vx_r) : 32'(vx_r);
    ay_v  = vy_r[31] ? 32'(-vy_r) : 32'(vy_r);
    sqx_v = 64'(ax_v) * 64'(ax_v);
    sqy_v = 64'(ay_v) * 64'(ay_v);
  end

  // wall test against the registered ram word
  logic signed [33:0] wl, wt, wr, wb, xe, ye;
  logic wall_hit;
  always_comb begin
    wl = 34'(signed'(ram_rdata[125:94]));
    wt = 34'(signed'(ram_rdata[93:62]));
    wr = wl + 34'({1'b0, ram_rdata[61:31]});
    wb = wt + 34'({1'b0, ram_rdata[30:0]});
    xe = 34'(x_r);
    ye = 34'(y_r);
    wall_hit = (xe > wl) && (xe < wr) && (ye > wt) && (ye < wb);
  end

  // one step of the root and the divider
  logic [63:0] bit_v, trial;
  logic [48:0] dtrial;
  always_comb begin
    bit_v  = 64'd1 << {iter_r, 1'b0};
    trial  = root_r + bit_v;
    dtrial = {rem_r[47:0], dnum_r[47]} - {13'd0, dden_r};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid && in_ch.cmd == CmdPoint) state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_SQRT;
      ST_SQRT: if (iter_r == 6'd0) state_nxt = ST_WAIT;
      ST_WAIT: state_nxt = (root_r == 64'd0) ? ST_RD : ST_DIVX;
      ST_DIVX: if (iter_r == 6'd48) state_nxt = ST_DIVY;
      ST_DIVY: if (iter_r == 6'd48) state_nxt = ST_RD;
      ST_RD:   state_nxt = (wall_r < (WallIdxW+1)'(nwalls)) ? ST_TEST : ST_OUT;
      ST_TEST: state_nxt = ST_PUSH;
      ST_PUSH: state_nxt = ST_PUSH;
      ST_OUT:  if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_PUSH) begin
      if (!wall_hit || mag_r == 32'd0 || steps_r >= StepCntW'(MaxBackoffSteps))
        state_nxt = ST_RD;
      else state_nxt = ST_PUSH;
    end
    if (state_r == ST_TEST) state_nxt = ST_PUSH;
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    unique case (state_r)
      ST_IDLE: begin
        px_r <= in_ch.pos_x; py_r <= in_ch.pos_y;
        vx_r <= vx_in; vy_r <= vy_in; x_r <= nx_in; y_r <= ny_in;
        hooked_r <= in_ch.hooked;
        pushed_r <= 1'b0; stuck_r <= 1'b0;
        sx_r <= '0; sy_r <= '0;
        root_r <= '0; iter_r <= 6'd31; wall_r <= '0;
      end
      ST_SQ: sq_r <= sqx_v + sqy_v;
      ST_SQRT: begin
        if (sq_r >= trial) begin
          sq_r <= sq_r - trial;
          root_r <= (root_r >> 1) + bit_v;
        end else root_r <= root_r >> 1;
        iter_r <= iter_r - 6'd1;
      end
      ST_WAIT: begin
        mag_r  <= root_r[31:0];
        dden_r <= 36'(root_r[31:0]) * 36'd10;
        dnum_r <= {ax_v, 16'd0};
        rem_r <= '0; quo_r <= '0; iter_r <= 6'd0;
      end
      ST_DIVX, ST_DIVY: begin
        if (iter_r == 6'd48) begin
          if (state_r == ST_DIVX) begin
            sx_r <= vx_r[31] ? -quo_r[31:0] : quo_r[31:0];
            dnum_r <= {ay_v, 16'd0};
          end else begin
            sy_r <= vy_r[31] ? -quo_r[31:0] : quo_r[31:0];
          end
          rem_r <= '0; quo_r <= '0; iter_r <= 6'd0;
        end else begin
          if (!dtrial[48]) begin
            rem_r <= 64'(dtrial[47:0]);
            quo_r <= {quo_r[46:0], 1'b1};
          end else begin
            rem_r <= {rem_r[62:0], dnum_r[47]};
            quo_r <= {quo_r[46:0], 1'b0};
          end
          dnum_r <= {dnum_r[46:0], 1'b0};
          iter_r <= iter_r + 6'd1;
        end
      end
      ST_RD: steps_r <= '0;
      ST_TEST: ;
      ST_PUSH: begin
        if (!wall_hit) begin
          wall_r <= wall_r + 1'b1;
        end else if (mag_r == 32'd0 || steps_r >= StepCntW'(MaxBackoffSteps)) begin
          stuck_r <= 1'b1;
          wall_r <= wall_r + 1'b1;
        end else begin
          x_r <= sat32(34'(x_r) - 34'(sx_r));
          y_r <= sat32(34'(y_r) - 34'(sy_r));
          steps_r <= steps_r + 1'b1;
          pushed_r <= 1'b1;
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  assign out_ch.valid       = (state_r == ST_OUT);
  assign out_ch.new_x       = hooked_r ? px_r : x_r;
  assign out_ch.new_y       = hooked_r ? py_r : y_r;
  assign out_ch.new_prev_x  = px_r;
  assign out_ch.new_prev_y  = py_r;
  assign out_ch.pushed_back = pushed_r;
  assign out_ch.stuck       = stuck_r;

  `VPW_ASSERT(a_onehot, $onehot(state_r), "state not one-hot")
  `VPW_ASSERT(a_no_accept_busy, (state_r != ST_IDLE) |-> !in_ch.ready, "accept while busy")
  `VPW_ASSERT(a_out_hold, (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.new_x), "result moved")
  `VPW_ASSERT(a_step_limit, (state_r == ST_PUSH) |-> (steps_r <= StepCntW'(MaxBackoffSteps)), "step count overran")
endmodule

// ===== bench/vpw_tb_if.sv =====
// note: interfaces come from the rtl (src/vpw_if.sv); this file holds bench helper types
`timescale 1ns / 1ps
package vpw_tb_pkg;
  typedef struct packed {
    logic        cmd;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] prev_x;
    logic [31:0] prev_y;
    logic        hooked;
    logic [2:0]  wall_index;
    logic [31:0] wall_left;
    logic [31:0] wall_top;
    logic [30:0] wall_width;
    logic [30:0] wall_height;
  } point_beat_t;

  typedef struct packed {
    logic [31:0] new_x;
    logic [31:0] new_y;
    logic [31:0] new_prev_x;
    logic [31:0] new_prev_y;
    logic        pushed_back;
    logic        stuck;
  } step_result_t;
endpackage

// ===== bench/tb_verlet_point_wall_pushback_unit.sv =====
// testbench for the verlet point wall push-back unit
`timescale 1ns / 1ps
module tb_verlet_point_wall_pushback_unit;
  import vpw_pkg::*;
  import vpw_tb_pkg::*;

  logic clk;
  logic rst_n;
  vpw_in_if  in_ch ();
  vpw_out_if out_ch ();
  vpw_cfg_if cfg_ch ();

  verlet_point_wall_pushback_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // shadow state of the block
  longint acc_x, acc_y;
  int unsigned walls_on;
  longint wl [MaxWalls];
  longint wt [MaxWalls];
  longint ww [MaxWalls];
  longint wh [MaxWalls];

  point_beat_t  pending_beats [$];
  step_result_t expected_steps [$];
  int errors;
  int results_seen;
  int n_pushed, n_stuck;
  int idle_cycles;
  bit hold_off_req;
  bit in_fired;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint tenth_step(longint v, longint unsigned den);
    longint unsigned a, q;
    a = (v < 0) ? longint'(-v) : longint'(v);
    q = (a << 16) / den;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit in_wall(longint x, longint y, int w);
    return x > wl[w] && x < wl[w] + ww[w] && y > wt[w] && y < wt[w] + wh[w];
  endfunction

  // update wall table or work out the step result of one point beat
  function automatic void predict_step(point_beat_t b);
    longint px, py, vx, vy, x, y, sx, sy;
    longint unsigned mag;
    int n, steps;
    step_result_t r;
    if (b.cmd == CmdWall) begin
      wl[b.wall_index] = sx32(b.wall_left);
      wt[b.wall_index] = sx32(b.wall_top);
      ww[b.wall_index] = longint'(b.wall_width);
      wh[b.wall_index] = longint'(b.wall_height);
      return;
    end
    r = '0;
    sx = 0;
    sy = 0;
    px = sx32(b.pos_x);
    py = sx32(b.pos_y);
    vx = clamp32(px - sx32(b.prev_x) + acc_x);
    vy = clamp32(py - sx32(b.prev_y) + acc_y);
    x = clamp32(px + vx);
    y = clamp32(py + vy);
    mag = int_root(longint'(vx * vx) + longint'(vy * vy));
    if (mag != 0) begin
      sx = tenth_step(vx, mag * 10);
      sy = tenth_step(vy, mag * 10);
    end
    n = (walls_on > MaxWalls) ? MaxWalls : walls_on;
    for (int w = 0; w < n; w++) begin
      steps = 0;
      if (!in_wall(x, y, w)) continue;
      if (mag == 0) begin
        r.stuck = 1'b1;
        continue;
      end
      while (in_wall(x, y, w)) begin
        if (steps >= MaxBackoffSteps) begin
          r.stuck = 1'b1;
          break;
        end
        x = clamp32(x - sx);
        y = clamp32(y - sy);
        steps++;
        r.pushed_back = 1'b1;
      end
    end
    if (b.hooked) begin
      x = px;
      y = py;
    end
    r.new_x = x[31:0];
    r.new_y = y[31:0];
    r.new_prev_x = b.pos_x;
    r.new_prev_y = b.pos_y;
    expected_steps.push_back(r);
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // input driver: one beat at a time from the pending queue
  int drv_gap;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CmdPoint; in_ch.pos_x = '0; in_ch.pos_y = '0;
    in_ch.prev_x = '0; in_ch.prev_y = '0; in_ch.hooked = 1'b0;
    in_ch.wall_index = '0; in_ch.wall_left = '0; in_ch.wall_top = '0;
    in_ch.wall_width = '0; in_ch.wall_height = '0;
    drv_gap = 0;
    in_fired = 1'b0;
  end
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fired) begin
        in_fired = 1'b0;
        drv_gap = gap_len();
      end
      if (drv_gap > 0) begin
        in_ch.valid <= 1'b0;
        drv_gap = drv_gap - 1;
      end else if (pending_beats.size() > 0) begin
        {in_ch.cmd, in_ch.pos_x, in_ch.pos_y, in_ch.prev_x, in_ch.prev_y, in_ch.hooked,
         in_ch.wall_index, in_ch.wall_left, in_ch.wall_top, in_ch.wall_width,
         in_ch.wall_height} <= pending_beats[0];
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // predict on acceptance at the rising edge and retire the beat
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_step({in_ch.cmd, in_ch.pos_x, in_ch.pos_y, in_ch.prev_x, in_ch.prev_y,
                    in_ch.hooked, in_ch.wall_index, in_ch.wall_left, in_ch.wall_top,
                    in_ch.wall_width, in_ch.wall_height});
      void'(pending_beats.pop_front());
      in_fired = 1'b1;
    end
  end

  // receiver readiness with random stalls and one long hold-off
  int rdy_gap, hold_cnt;
  initial begin
    out_ch.ready = 1'b0;
    rdy_gap = 0;
    hold_cnt = 0;
  end
  always @(negedge clk) begin
    if (hold_off_req && hold_cnt == 0) hold_cnt = 600;
    if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt = hold_cnt - 1;
      if (hold_cnt == 0) hold_off_req = 1'b0;
    end else if (rdy_gap > 0) begin
      out_ch.ready <= 1'b0;
      rdy_gap = rdy_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rdy_gap = gap_len();
    end
  end

  // result monitor
  always @(posedge clk) begin
    step_result_t got, exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.new_x, out_ch.new_y, out_ch.new_prev_x, out_ch.new_prev_y,
             out_ch.pushed_back, out_ch.stuck};
      results_seen++;
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_steps.pop_front();
        if (exp_r.pushed_back) n_pushed++;
        if (exp_r.stuck) n_stuck++;
        if (got.new_x !== exp_r.new_x)
          $display("%0t: new_x exp %h got %h", $time, exp_r.new_x, got.new_x);
        if (got.new_y !== exp_r.new_y)
          $display("%0t: new_y exp %h got %h", $time, exp_r.new_y, got.new_y);
        if (got.new_prev_x !== exp_r.new_prev_x)
          $display("%0t: new_prev_x exp %h got %h", $time, exp_r.new_prev_x,
                   got.new_prev_x);
        if (got.new_prev_y !== exp_r.new_prev_y)
          $display("%0t: new_prev_y exp %h got %h", $time, exp_r.new_prev_y,
                   got.new_prev_y);
        if (got.pushed_back !== exp_r.pushed_back)
          $display("%0t: pushed_back exp %b got %b", $time, exp_r.pushed_back,
                   got.pushed_back);
        if (got.stuck !== exp_r.stuck)
          $display("%0t: stuck exp %b got %b", $time, exp_r.stuck, got.stuck);
        if (got !== exp_r) errors++;
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 40000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CfgAccelX) acc_x = sx32(val);
    else if (idx == CfgAccelY) acc_y = sx32(val);
    else walls_on = 32'(val[3:0]);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || expected_steps.size() > 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 4)) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_wall(int idx, logic [31:0] l, logic [31:0] t,
                                   logic [30:0] w, logic [30:0] h);
    point_beat_t b;
    b = '0;
    b.cmd = CmdWall;
    b.wall_index = idx[2:0];
    b.wall_left = l; b.wall_top = t; b.wall_width = w; b.wall_height = h;
    b.pos_x = $urandom; b.prev_y = $urandom; b.hooked = 1'($urandom);
    pending_beats.push_back(b);
  endfunction

  function automatic void add_point(logic [31:0] px, logic [31:0] py, logic [31:0] qx,
                                    logic [31:0] qy, bit hk);
    point_beat_t b;
    b = '0;
    b.cmd = CmdPoint;
    b.pos_x = px; b.pos_y = py; b.prev_x = qx; b.prev_y = qy; b.hooked = hk;
    b.wall_index = 3'($urandom); b.wall_left = $urandom; b.wall_top = $urandom;
    b.wall_width = 31'($urandom); b.wall_height = 31'($urandom);
    pending_beats.push_back(b);
  endfunction

  // random point, mostly near the walls
  function automatic void add_rand_point();
    logic [31:0] px, py;
    int v;
    if ($urandom_range(0, 4) == 0) begin
      add_point(rnd32(), rnd32(), rnd32(), rnd32(), $urandom_range(0, 7) == 0);
    end else begin
      px = 32'(int'($urandom_range(0, 40 << 16)) - (20 << 16));
      py = 32'(int'($urandom_range(0, 40 << 16)) - (20 << 16));
      v = int'($urandom_range(0, 4 << 16)) - (2 << 16);
      add_point(px, py, px - 32'(v), py - 32'(int'($urandom_range(0, 4 << 16)) - (2 << 16)),
                $urandom_range(0, 7) == 0);
    end
  endfunction

  initial begin
    int phase;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CfgAccelX;
    cfg_ch.data = '0;
    errors = 0; results_seen = 0; n_pushed = 0; n_stuck = 0;
    idle_cycles = 0; hold_off_req = 1'b0;
    acc_x = 0; acc_y = 0; walls_on = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: fill all walls first, then corner cases
    for (int i = 0; i < MaxWalls; i++)
      add_wall(i, 32'(-(i * 2 + 4) << 16), 32'(-(i * 2 + 4) << 16),
               31'((i * 4 + 8) << 16), 31'((i * 4 + 8) << 16));
    drain();
    write_reg(CfgWallCount, 32'd8);
    add_point(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 1'b0); // zero v inside
    add_point(32'h00010000, 0, 0, 0, 1'b0);                 // push back
    add_point(32'h00010000, 0, 0, 0, 1'b1);                 // hooked
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1'b0);
    add_point(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
    add_point(0, 0, 32'h00000001, 0, 1'b0);                 // tiny v, small push-back steps
    add_point(32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    drain();
    write_reg(CfgWallCount, 32'd15);
    write_reg(CfgAccelX, 32'h7FFFFFFF);
    write_reg(CfgAccelY, 32'h80000000);
    add_point(0, 0, 0, 0, 1'b0);
    add_point(32'h00020000, 32'h00020000, 0, 0, 1'b1);
    drain();
    write_reg(CfgWallCount, 32'd0);
    add_point(32'h00030000, 0, 0, 0, 1'b0);
    add_wall(7, 32'h80000000, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF);
    add_wall(7, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h0, 31'h0);
    drain();

    // random phases with varied settings, one with a long receiver hold-off
    for (phase = 0; phase < 6; phase++) begin
      write_reg(CfgAccelX, (phase == 5) ? 32'h80000000 : 32'($urandom_range(0, 4096)) - 2048);
      write_reg(CfgAccelY, (phase == 5) ? 32'h7FFFFFFF : 32'($urandom_range(0, 4096)) - 2048);
      write_reg(CfgWallCount, (phase == 0) ? 32'd0 : 32'($urandom_range(1, 15)));
      if (phase == 2) hold_off_req = 1'b1;
      for (int k = 0; k < 88; k++) begin
        if ($urandom_range(0, 9) == 0)
          add_wall($urandom_range(0, 7), rnd32() >>> ($urandom_range(0, 1) * 12),
                   rnd32() >>> 12, 31'($urandom), 31'($urandom_range(0, 20 << 16)));
        else
          add_rand_point();
      end
      drain();
    end

    $display("run covered %0d point results, %0d pushed back, %0d stuck",
             results_seen, n_pushed, n_stuck);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
